### design/priority_wait_queue_assert.svh
// Assertion macros shared by the priority wait queue RTL.
// No dependencies; files include it by bare name.
`ifndef PRIORITY_WAIT_QUEUE_ASSERT_SVH
`define PRIORITY_WAIT_QUEUE_ASSERT_SVH

// expr holds at every edge out of reset
`define PWQ_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define PWQ_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define PWQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/pwq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the priority wait queue.
// No dependencies.
package pwq_pkg;

   localparam int TASK_ID_W = 16;
   localparam int PRIO_W    = 8;
   localparam int OPCODE_W  = 2;
   localparam int STATUS_W  = 2;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_CLR,
      IDX_LOAD_OCC,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_BELOW,
      RD_AT,
      RD_ABOVE
   } rd_off_type;

   typedef struct packed {
      logic                ld_req;
      idx_op_type          idx_op;
      logic                ram_rd;
      rd_off_type          rd_off;
      logic                ram_we;
      logic                wr_new;
      logic                occ_inc;
      logic                occ_dec;
      logic                res_ld;
      logic [STATUS_W-1:0] res_status;
      logic                res_head;
      logic                out_ld;
   } pwq_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                full;
      logic                empty;
      logic                idx_zero;
      logic                idx_at_occ;
      logic                idx_last;
      logic                prio_gt;
      logic                id_eq;
      logic                out_free;
   } pwq_sts_type;

endpackage

### design/priority_wait_queue.sv
`timescale 1ns / 1ps
// Top level of the priority wait queue: sorted task queue in one slot RAM.
// Depends on pwq_pkg, pwq_ctrl and pwq_dp.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_stall  | opcode, task_id, priority_req
//   rsp     | out       | rsp_valid / rsp_stall  | status, head_task_id, head_valid
//
// Insert walks down from the tail, moving entries up a slot until the new entry lands.
// Remove searches from the head and, on a hit, shifts the entries above it down a slot.
// A remove miss searches every entry. Peek reads the head slot; full insert, empty peek
// or other opcode answer straight from dispatch. Reset clears occupancy; no RAM sweep.
// A result held by rsp_stall sits in the output register; the next word is taken and
// its result waits until that register frees.
module priority_wait_queue
   import pwq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  logic [PRIO_W-1:0]    req_priority_req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [TASK_ID_W-1:0] rsp_head_task_id,
   output logic                 rsp_head_valid
);

   pwq_cmd_type cmd;
   pwq_sts_type sts;

   pwq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pwq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_head_task_id (rsp_head_task_id),
      .rsp_head_valid   (rsp_head_valid),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

### design/pwq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pwq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the priority wait queue: walks slots for insert and remove, reads the head for peek.
// Depends on pwq_pkg and priority_wait_queue_assert.svh.
`include "priority_wait_queue_assert.svh"
module pwq_ctrl
   import pwq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pwq_sts_type sts,
   output pwq_cmd_type cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_INS_CHK   = 4'd2;
   localparam logic [3:0] S_INS_CMP   = 4'd3;
   localparam logic [3:0] S_REM_CHK   = 4'd4;
   localparam logic [3:0] S_REM_CMP   = 4'd5;
   localparam logic [3:0] S_SH_CHK    = 4'd6;
   localparam logic [3:0] S_SH_WR     = 4'd7;
   localparam logic [3:0] S_PEEK_RD   = 4'd8;
   localparam logic [3:0] S_PEEK_WAIT = 4'd9;
   localparam logic [3:0] S_RESP      = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.idx_op = IDX_HOLD;
      cmd.rd_off = RD_AT;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.full) begin
                     cmd.res_ld     = 1'b1;
                     cmd.res_status = ST_FULL;
                     state_in       = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_LOAD_OCC;
                     state_in   = S_INS_CHK;
                  end
               end
               OP_REMOVE: begin
                  cmd.idx_op = IDX_CLR;
                  state_in   = S_REM_CHK;
               end
               OP_PEEK: begin
                  if (sts.empty) begin
                     cmd.res_ld     = 1'b1;
                     cmd.res_status = ST_EMPTY;
                     state_in       = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_CLR;
                     state_in   = S_PEEK_RD;
                  end
               end
               default: begin
                  cmd.res_ld     = 1'b1;
                  cmd.res_status = ST_OK;
                  state_in       = S_RESP;
               end
            endcase
         end
         S_INS_CHK: begin
            if (sts.idx_zero) begin
               cmd.ram_we     = 1'b1;
               cmd.wr_new     = 1'b1;
               cmd.occ_inc    = 1'b1;
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_RESP;
            end else begin
               cmd.ram_rd = 1'b1;
               cmd.rd_off = RD_BELOW;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            cmd.ram_we = 1'b1;
            if (sts.prio_gt) begin
               cmd.idx_op = IDX_DEC;
               state_in   = S_INS_CHK;
            end else begin
               cmd.wr_new     = 1'b1;
               cmd.occ_inc    = 1'b1;
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_RESP;
            end
         end
         S_REM_CHK: begin
            if (sts.idx_at_occ) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               state_in       = S_RESP;
            end else begin
               cmd.ram_rd = 1'b1;
               state_in   = S_REM_CMP;
            end
         end
         S_REM_CMP: begin
            if (sts.id_eq) begin
               state_in = S_SH_CHK;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_REM_CHK;
            end
         end
         S_SH_CHK: begin
            if (sts.idx_last) begin
               cmd.occ_dec    = 1'b1;
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_RESP;
            end else begin
               cmd.ram_rd = 1'b1;
               cmd.rd_off = RD_ABOVE;
               state_in   = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.ram_we = 1'b1;
            cmd.idx_op = IDX_INC;
            state_in   = S_SH_CHK;
         end
         S_PEEK_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_PEEK_WAIT;
         end
         S_PEEK_WAIT: begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_head   = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PWQ_ASSERT_HOLDS(a_occ_one_way, clock, reset, !(cmd.occ_inc && cmd.occ_dec), "occupancy up and down at once")
   `PWQ_ASSERT_IMPLIES(a_we_busy, clock, reset, cmd.ram_we, state_ff != S_IDLE, "slot write while idle")
   `PWQ_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && !req_stall, state_ff == S_DISPATCH, "accepted word not dispatched")

endmodule

### design/pwq_dp.sv
`timescale 1ns / 1ps
// Datapath for the priority wait queue: request latch, slot RAM, index, occupancy, result.
// Depends on pwq_pkg, pwq_ram and priority_wait_queue_assert.svh.
`include "priority_wait_queue_assert.svh"
module pwq_dp
   import pwq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  logic [PRIO_W-1:0]    req_priority_req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [TASK_ID_W-1:0] rsp_head_task_id,
   output logic                 rsp_head_valid,
   input  pwq_cmd_type          cmd,
   output pwq_sts_type          sts
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = ID_WIDTH + PRIO_W;

   logic [OPCODE_W-1:0]  req_op_ff;
   logic [ID_WIDTH-1:0]  req_id_ff;
   logic [PRIO_W-1:0]    req_prio_ff;
   logic [CW-1:0]        occ_ff, occ_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [STATUS_W-1:0]  res_status_ff;
   logic [ID_WIDTH-1:0]  res_head_ff;
   logic                 res_head_valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [TASK_ID_W-1:0] rsp_head_ff;
   logic                 rsp_head_valid_ff;

   logic [CW-1:0]        rd_idx;
   logic [DW-1:0]        rd_data;
   logic [DW-1:0]        wr_data;
   logic [ID_WIDTH-1:0]  rd_id;
   logic [PRIO_W-1:0]    rd_prio;

   assign rd_id   = rd_data[DW-1:PRIO_W];
   assign rd_prio = rd_data[PRIO_W-1:0];
   assign wr_data = cmd.wr_new ? {req_id_ff, req_prio_ff} : rd_data;

   always_comb begin
      case (cmd.rd_off)
         RD_BELOW: rd_idx = idx_ff - CW'(1);
         RD_AT:    rd_idx = idx_ff;
         RD_ABOVE: rd_idx = idx_ff + CW'(1);
         default:  rd_idx = idx_ff;
      endcase
   end

   pwq_ram #(
      .WIDTH (DW),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD:     idx_in = idx_ff;
         IDX_CLR:      idx_in = '0;
         IDX_LOAD_OCC: idx_in = occ_ff;
         IDX_INC:      idx_in = idx_ff + CW'(1);
         IDX_DEC:      idx_in = idx_ff - CW'(1);
         default:      idx_in = idx_ff;
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.occ_inc) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.ld_req) begin
         req_op_ff   <= req_opcode;
         req_id_ff   <= ID_WIDTH'(req_task_id);
         req_prio_ff <= req_priority_req;
      end
      if (cmd.res_ld) begin
         res_status_ff     <= cmd.res_status;
         res_head_ff       <= cmd.res_head ? rd_id : '0;
         res_head_valid_ff <= cmd.res_head;
      end
      if (cmd.out_ld) begin
         rsp_status_ff     <= res_status_ff;
         rsp_head_ff       <= TASK_ID_W'(res_head_ff);
         rsp_head_valid_ff <= res_head_valid_ff;
      end
   end

   assign sts.op         = req_op_ff;
   assign sts.full       = (occ_ff == CW'(QUEUE_DEPTH));
   assign sts.empty      = (occ_ff == '0);
   assign sts.idx_zero   = (idx_ff == '0);
   assign sts.idx_at_occ = (idx_ff == occ_ff);
   assign sts.idx_last   = ((idx_ff + CW'(1)) == occ_ff);
   assign sts.prio_gt    = (rd_prio > req_prio_ff);
   assign sts.id_eq      = (rd_id == req_id_ff);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_head_task_id = rsp_head_ff;
   assign rsp_head_valid   = rsp_head_valid_ff;

   `PWQ_ASSERT_HOLDS(a_occ_range, clock, reset, occ_ff <= CW'(QUEUE_DEPTH), "occupancy above depth")
   `PWQ_ASSERT_IMPLIES(a_ins_room, clock, reset, cmd.occ_inc, !sts.full, "insert into full queue")
   `PWQ_ASSERT_NEXT(a_out_loaded, clock, reset, cmd.out_ld, rsp_valid_ff, "result word lost")

endmodule
